@@ rtl/core/ntc_lin_pkg.sv @@
// Package for the NTC thermistor linearizer core.
// Holds the shared widths, the NTC resistance table, the sequencer states and
// the request and response structs of the shared divider. It has no dependencies.
`default_nettype none

package ntc_lin_pkg;

    localparam int ADC_BITS     = 12;
    localparam int TABLE_POINTS = 17;
    localparam int NTC_ENTRIES  = 17;

    localparam int CODE_W   = 12;
    localparam int RS_W     = 20;
    localparam int TEMP_W   = 8;
    localparam int STATUS_W = 2;
    localparam int TBL_W    = 18;
    localparam int NUM_W    = TBL_W + 3;
    localparam int PROD_W   = CODE_W + RS_W;
    localparam int DIVD_W   = PROD_W;
    localparam int DIVR_W   = (ADC_BITS + 1 > TBL_W) ? ADC_BITS + 1 : TBL_W;
    localparam int DCNT_W   = $clog2(DIVD_W);
    localparam int IDX_W    = $clog2(NTC_ENTRIES);
    localparam int N_SEARCH = (TABLE_POINTS < NTC_ENTRIES) ? TABLE_POINTS : NTC_ENTRIES;
    localparam int ADC_FULL = 1 << ADC_BITS;

    localparam logic [CODE_W-1:0] CODE_MASK =
        (ADC_BITS >= CODE_W) ? {CODE_W{1'b1}} : CODE_W'(ADC_FULL - 1);
    localparam logic [RS_W-1:0] RS_RESET = RS_W'(10700);

    localparam logic [TEMP_W-1:0] TEMP_BASE  = TEMP_W'(-45);
    localparam logic [TEMP_W-1:0] TEMP_ABOVE = TEMP_W'(-88);
    localparam logic [TEMP_W-1:0] TEMP_BELOW = TEMP_W'(88);
    localparam logic [TEMP_W-1:0] TEMP_STEP  = TEMP_W'(5);

    localparam int REG_SERIES_RES = 0;

    typedef enum logic [STATUS_W-1:0] {
        RANGE_IN    = 2'd0,
        RANGE_ABOVE = 2'd1,
        RANGE_BELOW = 2'd2
    } t_range;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START1,
        S_DIV1,
        S_SEARCH,
        S_START2,
        S_DIV2,
        S_OUT
    } t_state;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DIVR_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIVD_W-1:0] quotient;
        logic [DIVR_W-1:0] remainder;
    } t_div_rsp;

    function automatic logic [TBL_W-1:0] ntc_entry(input logic [IDX_W-1:0] idx);
        logic [TBL_W-1:0] val;
        case (idx)
            5'd0:    val = TBL_W'(205200);
            5'd1:    val = TBL_W'(154800);
            5'd2:    val = TBL_W'(117900);
            5'd3:    val = TBL_W'(90690);
            5'd4:    val = TBL_W'(70370);
            5'd5:    val = TBL_W'(55070);
            5'd6:    val = TBL_W'(43440);
            5'd7:    val = TBL_W'(34530);
            5'd8:    val = TBL_W'(27640);
            5'd9:    val = TBL_W'(22270);
            5'd10:   val = TBL_W'(18060);
            5'd11:   val = TBL_W'(14740);
            5'd12:   val = TBL_W'(12110);
            5'd13:   val = TBL_W'(10000);
            5'd14:   val = TBL_W'(8309);
            5'd15:   val = TBL_W'(6941);
            5'd16:   val = TBL_W'(5828);
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/ntc_lin_in_if.sv @@
// Input channel interface of the NTC thermistor linearizer.
// Carries one converter code per transaction; widths come from ntc_lin_pkg.
`default_nettype none

interface ntc_lin_in_if;
    logic                            valid;
    logic                            ready;
    logic [ntc_lin_pkg::CODE_W-1:0]  adc_code;

    modport source (output valid, output adc_code, input ready);
    modport sink   (input valid, input adc_code, output ready);
endinterface

`default_nettype wire

@@ rtl/core/ntc_lin_out_if.sv @@
// Output channel interface of the NTC thermistor linearizer.
// Carries one temperature and range status per transaction; widths from ntc_lin_pkg.
`default_nettype none

interface ntc_lin_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [ntc_lin_pkg::TEMP_W-1:0] temperature_c;
    logic [ntc_lin_pkg::STATUS_W-1:0]      range_status;

    modport source (output valid, output temperature_c, output range_status, input ready);
    modport sink   (input valid, input temperature_c, input range_status, output ready);
endinterface

`default_nettype wire

@@ rtl/core/ntc_lin_regs.sv @@
// APB-style configuration register file of the NTC thermistor linearizer.
// Holds the series resistance register; depends on ntc_lin_pkg.
`default_nettype none

module ntc_lin_regs (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [2:0]                   paddr,
    input  wire logic [31:0]                  pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    output logic [ntc_lin_pkg::RS_W-1:0]      o_series_res
);

    logic [ntc_lin_pkg::RS_W-1:0] r_series_res;
    logic                         sel_series;

    assign sel_series = (32'(paddr[2]) == ntc_lin_pkg::REG_SERIES_RES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_series_res <= ntc_lin_pkg::RS_RESET;
        end else if (psel && penable && pwrite && sel_series) begin
            r_series_res <= pwdata[ntc_lin_pkg::RS_W-1:0];
        end
    end

    assign pready       = 1'b1;
    assign prdata       = sel_series ? 32'(r_series_res) : '0;
    assign o_series_res = r_series_res;

endmodule

`default_nettype wire

@@ rtl/core/ntc_lin_div.sv @@
// Shared restoring divider of the NTC thermistor linearizer, one quotient bit per cycle.
// Used for both the resistance and the interpolation division; depends on ntc_lin_pkg.
`default_nettype none

module ntc_lin_div (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire ntc_lin_pkg::t_div_req i_req,
    output ntc_lin_pkg::t_div_rsp      o_rsp
);

    localparam int DIVD_W = ntc_lin_pkg::DIVD_W;
    localparam int DIVR_W = ntc_lin_pkg::DIVR_W;
    localparam int DCNT_W = ntc_lin_pkg::DCNT_W;

    logic              r_busy;
    logic              r_done;
    logic [DCNT_W-1:0] r_cnt;
    logic [DIVR_W-1:0] r_rem;
    logic [DIVR_W-1:0] r_dvs;
    logic [DIVD_W-1:0] r_quo;
    logic [DIVR_W:0]   shifted;
    logic [DIVR_W:0]   diff;

    assign shifted = {r_rem, r_quo[DIVD_W-1]};
    assign diff    = shifted - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DCNT_W'(DIVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_dvs <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            if (!diff[DIVR_W]) begin
                r_rem <= diff[DIVR_W-1:0];
                r_quo <= {r_quo[DIVD_W-2:0], 1'b1};
            end else begin
                r_rem <= shifted[DIVR_W-1:0];
                r_quo <= {r_quo[DIVD_W-2:0], 1'b0};
            end
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |=> r_busy)
        else $error("divider did not start");

    a_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < r_dvs))
        else $error("divider remainder not below divisor");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("divider done held longer than one cycle");

endmodule

`default_nettype wire

@@ rtl/core/ntc_thermistor_linearizer_core.sv @@
// NTC thermistor linearizer, top level.
// Accepts one divider converter code and returns a temperature in whole degrees and a
// range status. The input channel is a valid/ready sink: a transaction completes when
// valid and ready are both high. Ready is high only while the core is idle, so one item
// is in work at a time. The resistance code*Rs/(2^ADC_BITS-code) is found by a shared
// one-bit-per-cycle restoring divider, then the NTC table is walked one entry per
// cycle, then the same divider forms the interpolation quotient, which is rounded to
// nearest, ties to even, as the divider finishes. Latency from input transaction to
// output valid, set by the two divider passes and the table walk, depends on whether
// the resistance lies above the table, at or below the last entry, or within it. The
// next item is taken the cycle after the result transaction. A stalled receiver holds
// the result in the output register and keeps the core from taking new input.
// Reset (i_rst_n low, synchronous) returns the sequencer to idle and the series
// resistance register to 10700 ohms; there is no clearing pass. The user must write the
// series resistance through the APB-style port at byte address 0 only while the core
// is idle; the block itself does not enforce this.
`default_nettype none

module ntc_thermistor_linearizer_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    ntc_lin_in_if.sink       i_in,
    ntc_lin_out_if.source    o_out
);

    localparam int TBL_W    = ntc_lin_pkg::TBL_W;
    localparam int IDX_W    = ntc_lin_pkg::IDX_W;
    localparam int NUM_W    = ntc_lin_pkg::NUM_W;
    localparam int PROD_W   = ntc_lin_pkg::PROD_W;
    localparam int DIVD_W   = ntc_lin_pkg::DIVD_W;
    localparam int DIVR_W   = ntc_lin_pkg::DIVR_W;
    localparam int TEMP_W   = ntc_lin_pkg::TEMP_W;
    localparam int STATUS_W = ntc_lin_pkg::STATUS_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ntc_lin_pkg::N_SEARCH - 1);

    logic [ntc_lin_pkg::RS_W-1:0]   series_res;
    logic [ntc_lin_pkg::CODE_W-1:0] code_m;

    ntc_lin_pkg::t_state  r_state, n_state;
    ntc_lin_pkg::t_div_req div_req;
    ntc_lin_pkg::t_div_rsp div_rsp;

    logic [PROD_W-1:0]   r_prod,   n_prod;
    logic [DIVR_W-1:0]   r_dvs,    n_dvs;
    logic [DIVD_W-1:0]   r_res,    n_res;
    logic [IDX_W-1:0]    r_idx,    n_idx;
    logic [TBL_W-1:0]    r_x1,     n_x1;
    logic [NUM_W-1:0]    r_num,    n_num;
    logic [TBL_W-1:0]    r_den,    n_den;
    logic [TEMP_W-1:0]   r_temp,   n_temp;
    logic [STATUS_W-1:0] r_status, n_status;

    logic [TBL_W-1:0]  entry;
    logic [TBL_W-1:0]  gap;
    logic [TEMP_W-1:0] t_sum;
    logic [DIVR_W:0]   rem_x2;
    logic              round_up;

    ntc_lin_regs u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_series_res (series_res)
    );

    ntc_lin_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign code_m = i_in.adc_code & ntc_lin_pkg::CODE_MASK;
    assign entry  = ntc_lin_pkg::ntc_entry(r_idx);
    assign gap    = r_x1 - r_res[TBL_W-1:0];
    assign t_sum  = ntc_lin_pkg::TEMP_BASE
                  + TEMP_W'({3'b000, r_idx} * ntc_lin_pkg::TEMP_STEP)
                  + {5'b00000, div_rsp.quotient[2:0]};
    assign rem_x2 = {div_rsp.remainder, 1'b0};
    assign round_up = (rem_x2 > {1'b0, DIVR_W'(r_den)})
                   || ((rem_x2 == {1'b0, DIVR_W'(r_den)}) && t_sum[0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ntc_lin_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod   <= n_prod;
        r_dvs    <= n_dvs;
        r_res    <= n_res;
        r_idx    <= n_idx;
        r_x1     <= n_x1;
        r_num    <= n_num;
        r_den    <= n_den;
        r_temp   <= n_temp;
        r_status <= n_status;
    end

    always_comb begin
        n_state  = r_state;
        n_prod   = r_prod;
        n_dvs    = r_dvs;
        n_res    = r_res;
        n_idx    = r_idx;
        n_x1     = r_x1;
        n_num    = r_num;
        n_den    = r_den;
        n_temp   = r_temp;
        n_status = r_status;
        div_req.start    = 1'b0;
        div_req.dividend = r_prod;
        div_req.divisor  = r_dvs;
        i_in.ready  = 1'b0;
        o_out.valid = 1'b0;
        unique case (r_state)
            ntc_lin_pkg::S_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    n_prod  = PROD_W'(code_m) * PROD_W'(series_res);
                    n_dvs   = DIVR_W'(ntc_lin_pkg::ADC_FULL) - DIVR_W'(code_m);
                    n_state = ntc_lin_pkg::S_START1;
                end
            end
            ntc_lin_pkg::S_START1: begin
                div_req.start = 1'b1;
                n_state       = ntc_lin_pkg::S_DIV1;
            end
            ntc_lin_pkg::S_DIV1: begin
                if (div_rsp.done) begin
                    n_res   = div_rsp.quotient;
                    n_idx   = '0;
                    n_state = ntc_lin_pkg::S_SEARCH;
                end
            end
            ntc_lin_pkg::S_SEARCH: begin
                if (r_res > DIVD_W'(entry)) begin
                    if (r_idx == '0) begin
                        n_temp   = ntc_lin_pkg::TEMP_ABOVE;
                        n_status = ntc_lin_pkg::RANGE_ABOVE;
                        n_state  = ntc_lin_pkg::S_OUT;
                    end else begin
                        n_num   = (NUM_W'(gap) << 2) + NUM_W'(gap);
                        n_den   = r_x1 - entry;
                        n_state = ntc_lin_pkg::S_START2;
                    end
                end else if (r_idx == LAST_IDX) begin
                    n_temp   = ntc_lin_pkg::TEMP_BELOW;
                    n_status = ntc_lin_pkg::RANGE_BELOW;
                    n_state  = ntc_lin_pkg::S_OUT;
                end else begin
                    n_x1  = entry;
                    n_idx = r_idx + 1'b1;
                end
            end
            ntc_lin_pkg::S_START2: begin
                div_req.start    = 1'b1;
                div_req.dividend = DIVD_W'(r_num);
                div_req.divisor  = DIVR_W'(r_den);
                n_state          = ntc_lin_pkg::S_DIV2;
            end
            ntc_lin_pkg::S_DIV2: begin
                if (div_rsp.done) begin
                    n_temp   = t_sum + TEMP_W'(round_up);
                    n_status = ntc_lin_pkg::RANGE_IN;
                    n_state  = ntc_lin_pkg::S_OUT;
                end
            end
            ntc_lin_pkg::S_OUT: begin
                o_out.valid = 1'b1;
                if (o_out.ready) begin
                    n_state = ntc_lin_pkg::S_IDLE;
                end
            end
        endcase
    end

    assign o_out.temperature_c = $signed(r_temp);
    assign o_out.range_status  = r_status;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input taken while an item is in work");

    a_above_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.range_status == ntc_lin_pkg::RANGE_ABOVE)
            |-> (r_temp == ntc_lin_pkg::TEMP_ABOVE))
        else $error("above-table result without -88");

    a_below_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.range_status == ntc_lin_pkg::RANGE_BELOW)
            |-> (r_temp == ntc_lin_pkg::TEMP_BELOW))
        else $error("below-table result without 88");

endmodule

`default_nettype wire
